// ----- design/vnf_pkg.sv -----
// Shared constants and types for the fractal value noise generator.
`timescale 1ns / 1ps
package vnf_pkg;

  localparam int NUM_OCT       = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int APB_AW        = 3;

  localparam logic [31:0] HASH_MUL_A = 32'h85EBCA6B;
  localparam logic [31:0] HASH_MUL_B = 32'hC2B2AE35;
  localparam logic [31:0] HASH_MUL_C = 32'h9E3779B1;
  localparam logic [31:0] SEED_STEP  = 32'd131;

  // floor(2^24 / 7), used for the final divide by seven
  localparam logic [21:0] RECIP_7    = 22'd2396745;

  localparam logic [APB_AW-1:0] ADDR_NOISE_SEED = 3'd0;

  typedef struct packed {
    logic [31:0] ix0;
    logic [31:0] ix1;
    logic [31:0] iy0;
    logic [31:0] iy1;
    logic [15:0] fx;
    logic [15:0] fy;
  } oct_cell_t;

  typedef oct_cell_t [NUM_OCT-1:0] cell_set_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

endpackage

// ----- design/vnf_front.sv -----
// Front end: splits a coordinate into lattice cells and fractions per octave.
`timescale 1ns / 1ps
module vnf_front #(
  parameter int FRAC_BITS = vnf_pkg::FRAC_BITS_DEF
) (
  input  logic [31:0]        coord_x_i,
  input  logic [31:0]        coord_y_i,
  output vnf_pkg::cell_set_t cells_o
);
  import vnf_pkg::*;

  for (genvar k = 0; k < NUM_OCT; k++) begin : g_oct
    logic [33:0]           sx, sy;
    logic signed [33:0]    cx, cy;
    logic [FRAC_BITS+15:0] fwx, fwy;

    assign sx  = {{2{coord_x_i[31]}}, coord_x_i} << k;
    assign sy  = {{2{coord_y_i[31]}}, coord_y_i} << k;
    assign cx  = $signed(sx) >>> FRAC_BITS;
    assign cy  = $signed(sy) >>> FRAC_BITS;
    // fraction to Q0.16: truncate or shift up depending on FRAC_BITS
    assign fwx = {sx[FRAC_BITS-1:0], 16'b0};
    assign fwy = {sy[FRAC_BITS-1:0], 16'b0};

    assign cells_o[k].ix0 = cx[31:0];
    assign cells_o[k].ix1 = cx[31:0] + 32'd1;
    assign cells_o[k].iy0 = cy[31:0];
    assign cells_o[k].iy1 = cy[31:0] + 32'd1;
    assign cells_o[k].fx  = fwx[FRAC_BITS+15:FRAC_BITS];
    assign cells_o[k].fy  = fwy[FRAC_BITS+15:FRAC_BITS];
  end

endmodule

// ----- design/vnf_queue.sv -----
// Small register queue between the front end and the noise pipeline.
`timescale 1ns / 1ps
module vnf_queue #(
  parameter int DEPTH = vnf_pkg::QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  vnf_pkg::cell_set_t     push_data_i,
  input  logic                   pop_i,
  output vnf_pkg::cell_set_t     head_o,
  output vnf_pkg::queue_status_t status_o
);
  import vnf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cell_set_t       mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) r = '0;
    else                     r = p + PW'(1);
    return r;
  endfunction

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign head_o             = mem_q[rd_q];
  assign status_o.not_empty = (cnt_q != '0);
  assign status_o.full      = (cnt_q == CW'(DEPTH));

endmodule

// ----- design/vnf_back.sv -----
// Noise pipeline: corner hashing, smoothstep, interpolation, octave sum, scaling.
`timescale 1ns / 1ps
module vnf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vnf_pkg::cell_set_t cells_i,
  input  logic               head_valid_i,
  input  logic [31:0]        seed_i,
  input  logic               out_stall_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output logic [15:0]        noise_value_o
);
  import vnf_pkg::*;

  logic        en;
  logic [7:1]  v_q;
  logic        out_valid_q;
  logic [15:0] noise_q;

  logic [31:0] sm_q  [NUM_OCT];
  logic [31:0] p1_q  [NUM_OCT][4];
  logic [31:0] h2_q  [NUM_OCT][4];
  logic [31:0] h3_q  [NUM_OCT][4];
  logic [15:0] f1_q  [NUM_OCT][2];
  logic [31:0] f2_q  [NUM_OCT][2];
  logic [49:0] s2_q  [NUM_OCT][2];
  logic [16:0] sw3_q [NUM_OCT][2];
  logic [16:0] sy4_q [NUM_OCT];
  logic [31:0] tb4_q [NUM_OCT][2];
  logic [48:0] vp5_q [NUM_OCT][2];
  logic [19:0] u6_q, u7_q;
  logic [17:0] q7_q;

  // the whole pipeline moves unless a finished result is held
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[6:1], pop_o};
      out_valid_q <= v_q[7];
    end
  end

  for (genvar k = 0; k < NUM_OCT; k++) begin : g_oct
    // octave seed product; the user must change the seed only while idle, this block does not enforce it
    always_ff @(posedge clk_i) begin
      sm_q[k] <= (seed_i + 32'(k) * SEED_STEP) * HASH_MUL_C;
    end

    for (genvar c = 0; c < 4; c++) begin : g_corner
      logic [31:0] ix, iy, m2, m3;
      assign ix = c[0] ? cells_i[k].ix1 : cells_i[k].ix0;
      assign iy = c[1] ? cells_i[k].iy1 : cells_i[k].iy0;
      assign m2 = h2_q[k][c] ^ (h2_q[k][c] >> 13);
      assign m3 = p1_q[k][c] ^ (p1_q[k][c] >> 15);
      always_ff @(posedge clk_i) begin
        if (en) begin
          p1_q[k][c] <= (ix * HASH_MUL_A) ^ (iy * HASH_MUL_B) ^ sm_q[k];
          h2_q[k][c] <= m3 * HASH_MUL_A;
          h3_q[k][c] <= m2 * HASH_MUL_B;
        end
      end
    end

    for (genvar d = 0; d < 2; d++) begin : g_axis
      logic [15:0] f;
      logic [17:0] w;
      logic [49:0] sr;
      assign f  = d ? cells_i[k].fy : cells_i[k].fx;
      assign w  = 18'd196608 - {1'b0, f1_q[k][d], 1'b0};
      assign sr = s2_q[k][d] + 50'h0_0000_8000_0000;
      always_ff @(posedge clk_i) begin
        if (en) begin
          f1_q[k][d]  <= f;
          f2_q[k][d]  <= 32'(f) * 32'(f);
          s2_q[k][d]  <= 50'(f2_q[k][d]) * 50'(w);
          sw3_q[k][d] <= sr[48:32];
        end
      end
    end

    // bilinear blend; corner value is the top half of the final hash
    logic [16:0] isx, isy;
    assign isx = 17'h10000 - sw3_q[k][0];
    assign isy = 17'h10000 - sy4_q[k];

    for (genvar r = 0; r < 2; r++) begin : g_row
      logic [32:0] lhs, rhs;
      assign lhs = 33'(h3_q[k][2*r][31:16]) * 33'(isx);
      assign rhs = 33'(h3_q[k][2*r+1][31:16]) * 33'(sw3_q[k][0]);
      always_ff @(posedge clk_i) begin
        if (en) begin
          tb4_q[k][r] <= 32'(lhs + rhs);
          vp5_q[k][r] <= 49'(tb4_q[k][r]) * 49'(r ? sy4_q[k] : isy);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) sy4_q[k] <= sw3_q[k][1];
    end
  end

  // 4*v0 + 2*v1 + v2 plus half of the 7*2^32 divisor
  logic [51:0] total;
  always_comb begin
    total = 52'h3_8000_0000;
    for (int k = 0; k < NUM_OCT; k++) begin
      total = total + ((52'(vp5_q[k][0]) + 52'(vp5_q[k][1])) << (NUM_OCT - 1 - k));
    end
  end

  logic [41:0] qprod;
  logic [19:0] rem;
  logic [17:0] qf;
  assign qprod = 42'(u6_q) * 42'(RECIP_7);
  assign rem   = u7_q - 20'(q7_q) * 20'd7;
  assign qf    = q7_q + 18'(rem >= 20'd7);

  always_ff @(posedge clk_i) begin
    if (en) begin
      u6_q    <= total[51:32];
      u7_q    <= u6_q;
      q7_q    <= qprod[41:24];
      noise_q <= (qf > 18'd65535) ? 16'hFFFF : qf[15:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

endmodule

// ----- design/value_noise_fbm_generator_unit.sv -----
// Top level of the three-octave fractal value noise generator.
// Takes one signed fixed-point (x, y) coordinate per transaction and returns one
// Q0.16 noise sample. It accepts a coordinate every cycle while the queue is
// not full; each result passes through the eight-stage noise pipeline (three
// hash multiply stages, blend stages and the divide-by-seven reciprocal). A
// four-entry queue sits between the coordinate front end and the pipeline, so
// input and output stalls are absorbed separately. The seed register sits at
// address 0 of the APB port and must only be written while no transaction is
// in flight.
`timescale 1ns / 1ps
module value_noise_fbm_generator_unit #(
  parameter int FRAC_BITS   = vnf_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = vnf_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vnf_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [31:0]         coord_x_i,
  input  logic signed [31:0]         coord_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [15:0]                noise_value_o
);
  import vnf_pkg::*;

  logic          [31:0] seed_q;
  cell_set_t            front_cells, head_cells;
  queue_status_t        qstat;
  logic                 push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_NOISE_SEED) begin
      seed_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NOISE_SEED) ? seed_q : '0;

  assign push       = in_valid_i && !qstat.full;
  assign in_stall_o = qstat.full;

  vnf_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .cells_o   (front_cells)
  );

  vnf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cells),
    .pop_i       (pop),
    .head_o      (head_cells),
    .status_o    (qstat)
  );

  vnf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cells_i       (head_cells),
    .head_valid_i  (qstat.not_empty),
    .seed_i        (seed_q),
    .out_stall_i   (out_stall_i),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .noise_value_o (noise_value_o)
  );

endmodule

// ----- design/vnf_checker.sv -----
// Port-level checks for the noise generator, bound to the top level.
`timescale 1ns / 1ps
module vnf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] noise_value_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o))
    else $error("stalled result changed");

  // with no result waiting the pipeline drains the queue, so input is free next cycle
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stalled while output empty");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o && pready)
    else $error("outputs active in reset");

endmodule

bind value_noise_fbm_generator_unit vnf_checker u_vnf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .noise_value_o (noise_value_o)
);
